@@ rtl/okb_pkg.sv @@
package okb_pkg;

    // Field widths
    localparam int QW  = 34;  // heading vector components (Q30)
    localparam int VW  = 38;  // vectoring datapath, room for CORDIC gain
    localparam int ZW  = 34;  // angle, Q30 radians
    localparam int RW  = 36;  // cosine / sine datapath, Q30
    localparam int CW  = 24;  // map coordinates
    localparam int AW  = 18;  // along / across offsets in half millimetres
    localparam int MAX_STEPS = 24;

    // Result status codes
    localparam logic [1:0] STAT_CORNER  = 2'd0;
    localparam logic [1:0] STAT_IDLE    = 2'd1;
    localparam logic [1:0] STAT_NO_AREA = 2'd2;

    // Angle and gain constants, Q30
    localparam logic signed [ZW-1:0] HALF_PI  = 34'sd1686629713;
    localparam logic signed [ZW-1:0] PI       = 34'sd3373259426;
    localparam logic signed [RW-1:0] INV_GAIN = 36'sd652032874;

    // Data that rides along with each item through the pipeline
    typedef struct packed {
        logic [1:0]           status;
        logic signed [CW-1:0] pose_x;
        logic signed [CW-1:0] pose_y;
        logic [7:0]           area;
    } side_t;

    // Arctangent of 2^-i, Q30, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] r;
        r = '0;
        case (i)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048576;
            11: r = 34'sd524288;
            12: r = 34'sd262144;
            13: r = 34'sd131072;
            14: r = 34'sd65536;
            15: r = 34'sd32768;
            16: r = 34'sd16384;
            17: r = 34'sd8192;
            18: r = 34'sd4096;
            19: r = 34'sd2048;
            20: r = 34'sd1024;
            21: r = 34'sd512;
            22: r = 34'sd256;
            23: r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/oriented_keepout_box_corners_unit.sv @@
// Channel  | Direction | tdata (low bit up)                                  | tuser   | tlast
// s_       | in        | pose_x 24, pose_y 24, quat_w/x/y/z 16 each, area 9  | pending | -
// m_       | out       | corner_number 2, corner_x 24, corner_y 24, area 8   | status  | last
// APB      | in        | regs at 0x0 width, 0x4 length, 0x8 center, 0xC depth| -       | -
//
// From accept to first result an item passes stages A and B (heading vector), one
// pipeline stage per CORDIC iteration in each of the two CORDICs (STEPS = CORDIC_STEPS,
// at most 24) plus the entry stage of both and the rotator's exit stage, three corner
// stages and the output register. Results leave it at one per cycle while m_tready is
// high: four per corner item, one per status-only item, with the pipeline held meanwhile.
// Reset (aresetn low, synchronous) clears valid bits and loads register defaults.
// A stall on m_tready freezes the whole pipeline; nothing is lost or repeated.
module oriented_keepout_box_corners_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // pose_x, pose_y, quat_w, quat_x, quat_y, quat_z, area_num
    input  logic [0:0]   s_tuser,   // pending
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // corner_number, corner_x_mm, corner_y_mm, area_out
    output logic [1:0]   m_tuser,   // status
    output logic         m_tlast,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import okb_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_CENTER = 2'd2;
    localparam logic [1:0] REG_DEPTH  = 2'd3;

    // Configuration registers
    logic [11:0] width_reg, length_reg, center_reg, depth_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 12'd400;
            length_reg <= 12'd540;
            center_reg <= 12'd180;
            depth_reg  <= 12'd100;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[11:0];
                REG_LENGTH: length_reg <= pwdata[11:0];
                REG_CENTER: center_reg <= pwdata[11:0];
                REG_DEPTH:  depth_reg  <= pwdata[11:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {20'd0, width_reg};
            REG_LENGTH: prdata = {20'd0, length_reg};
            REG_CENTER: prdata = {20'd0, center_reg};
            REG_DEPTH:  prdata = {20'd0, depth_reg};
            default:    prdata = '0;
        endcase
    end

    // Global pipeline advance
    logic en;
    assign s_tready = en;

    // Unpack the input item
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [8:0]  area_in;
    side_t              in_side;

    assign qw      = s_tdata[63:48];
    assign qx      = s_tdata[79:64];
    assign qy      = s_tdata[95:80];
    assign qz      = s_tdata[111:96];
    assign area_in = s_tdata[120:112];

    always_comb begin
        in_side.pose_x = s_tdata[23:0];
        in_side.pose_y = s_tdata[47:24];
        in_side.area   = area_in[7:0];
        if (!s_tuser[0]) begin
            in_side.status = STAT_IDLE;
        end else if (area_in[8]) begin
            in_side.status = STAT_NO_AREA;
        end else begin
            in_side.status = STAT_CORNER;
        end
    end

    // Stage A: quaternion products
    logic               a_valid_reg;
    side_t              a_side_reg;
    logic signed [31:0] wz_reg, xy_reg, yy_reg, zz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= in_side;
            wz_reg     <= qw * qz;
            xy_reg     <= qx * qy;
            yy_reg     <= qy * qy;
            zz_reg     <= qz * qz;
        end
    end

    // Stage B: heading vector, Q30
    logic                 b_valid_reg;
    side_t                b_side_reg;
    logic signed [QW-1:0] num_reg, den_reg;
    logic signed [32:0]   num_half, sq_sum;

    assign num_half = 33'(wz_reg) + 33'(xy_reg);
    assign sq_sum   = 33'(yy_reg) + 33'(zz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_side_reg <= a_side_reg;
            num_reg    <= {num_half, 1'b0};
            den_reg    <= 34'sd1073741824 - {sq_sum, 1'b0};
        end
    end

    // Heading angle
    logic                 v_valid;
    logic signed [ZW-1:0] v_z;
    side_t                v_side;

    okb_vector #(.STEPS(STEPS)) u_vector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b_valid_reg),
        .in_x      (den_reg),
        .in_y      (num_reg),
        .in_side   (b_side_reg),
        .out_valid (v_valid),
        .out_z     (v_z),
        .out_side  (v_side)
    );

    // Cosine and sine of the heading
    logic                 r_valid;
    logic signed [RW-1:0] r_cos, r_sin;
    side_t                r_side;

    okb_rotate #(.STEPS(STEPS)) u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_valid),
        .in_z      (v_z),
        .in_side   (v_side),
        .out_valid (r_valid),
        .out_cos   (r_cos),
        .out_sin   (r_sin),
        .out_side  (r_side)
    );

    // Corner placement
    logic                 c_valid;
    side_t                c_side;
    logic signed [CW-1:0] c_x [0:3];
    logic signed [CW-1:0] c_y [0:3];

    okb_corner u_corner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_cos    (r_cos),
        .in_sin    (r_sin),
        .in_side   (r_side),
        .width_mm  (width_reg),
        .length_mm (length_reg),
        .center_mm (center_reg),
        .depth_mm  (depth_reg),
        .out_valid (c_valid),
        .out_side  (c_side),
        .out_x     (c_x),
        .out_y     (c_y)
    );

    // Output register: holds one item and hands out its results in order
    logic                 full_reg;
    side_t                o_side_reg;
    logic signed [CW-1:0] o_x_reg [0:3];
    logic signed [CW-1:0] o_y_reg [0:3];
    logic [1:0]           cnt_reg;
    logic                 is_last;

    assign is_last = (o_side_reg.status != STAT_CORNER) || (cnt_reg == 2'd3);
    assign en      = !full_reg || (m_tready && is_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else if (en) begin
            full_reg <= c_valid;
            cnt_reg  <= 2'd0;
        end else if (m_tready) begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_side_reg <= c_side;
            o_x_reg    <= c_x;
            o_y_reg    <= c_y;
        end
    end

    // Result fields
    logic                 corner_ok;
    logic [CW-1:0]        sel_x, sel_y;

    assign corner_ok = (o_side_reg.status == STAT_CORNER);
    assign sel_x     = corner_ok ? o_x_reg[cnt_reg] : '0;
    assign sel_y     = corner_ok ? o_y_reg[cnt_reg] : '0;

    assign m_tvalid = full_reg;
    assign m_tuser  = o_side_reg.status;
    assign m_tlast  = is_last;
    assign m_tdata  = {6'd0,
                       corner_ok ? o_side_reg.area : 8'd0,
                       sel_y,
                       sel_x,
                       corner_ok ? cnt_reg : 2'd0};

endmodule

@@ rtl/okb_vector.sv @@
module okb_vector #(
    parameter int STEPS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [okb_pkg::QW-1:0] in_x,
    input  logic signed [okb_pkg::QW-1:0] in_y,
    input  okb_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic signed [okb_pkg::ZW-1:0] out_z,
    output okb_pkg::side_t                out_side
);
    import okb_pkg::*;

    logic                 valid_reg [0:STEPS];
    logic                 zero_reg  [0:STEPS];
    logic signed [VW-1:0] x_reg     [0:STEPS];
    logic signed [VW-1:0] y_reg     [0:STEPS];
    logic signed [ZW-1:0] z_reg     [0:STEPS];
    side_t                side_reg  [0:STEPS];

    logic signed [VW-1:0] x_ext, y_ext;
    assign x_ext = {{(VW-QW){in_x[QW-1]}}, in_x};
    assign y_ext = {{(VW-QW){in_y[QW-1]}}, in_y};

    // Entry stage: quarter turn into the right half plane
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            if (!in_x[QW-1]) begin
                x_reg[0] <= x_ext;
                y_reg[0] <= y_ext;
                z_reg[0] <= '0;
            end else if (!in_y[QW-1]) begin
                x_reg[0] <= y_ext;
                y_reg[0] <= -x_ext;
                z_reg[0] <= HALF_PI;
            end else begin
                x_reg[0] <= -y_ext;
                y_reg[0] <= x_ext;
                z_reg[0] <= -HALF_PI;
            end
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i+1] <= side_reg[i];
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][VW-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_side  = side_reg[STEPS];
    assign out_z     = zero_reg[STEPS] ? '0 : z_reg[STEPS];

endmodule

@@ rtl/okb_rotate.sv @@
module okb_rotate #(
    parameter int STEPS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [okb_pkg::ZW-1:0] in_z,
    input  okb_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic signed [okb_pkg::RW-1:0] out_cos,
    output logic signed [okb_pkg::RW-1:0] out_sin,
    output okb_pkg::side_t                out_side
);
    import okb_pkg::*;

    logic                 valid_reg [0:STEPS];
    logic                 flip_reg  [0:STEPS];
    logic signed [RW-1:0] x_reg     [0:STEPS];
    logic signed [RW-1:0] y_reg     [0:STEPS];
    logic signed [ZW-1:0] z_reg     [0:STEPS];
    side_t                side_reg  [0:STEPS];

    logic                 out_valid_reg;
    logic signed [RW-1:0] cos_reg, sin_reg;
    side_t                out_side_reg;

    // Entry stage: fold the angle by half a turn when past a right angle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            x_reg[0]    <= INV_GAIN;
            y_reg[0]    <= '0;
            if (in_z > HALF_PI) begin
                z_reg[0]    <= in_z - PI;
                flip_reg[0] <= 1'b1;
            end else if (in_z < -HALF_PI) begin
                z_reg[0]    <= in_z + PI;
                flip_reg[0] <= 1'b1;
            end else begin
                z_reg[0]    <= in_z;
                flip_reg[0] <= 1'b0;
            end
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i+1] <= side_reg[i];
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][ZW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
            end
        end
    end

    // Exit stage: undo the fold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= valid_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_side_reg <= side_reg[STEPS];
            cos_reg      <= flip_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
            sin_reg      <= flip_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_side  = out_side_reg;

endmodule

@@ rtl/okb_corner.sv @@
module okb_corner (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [okb_pkg::RW-1:0] in_cos,
    input  logic signed [okb_pkg::RW-1:0] in_sin,
    input  okb_pkg::side_t                in_side,
    input  logic [11:0]                   width_mm,
    input  logic [11:0]                   length_mm,
    input  logic signed [11:0]            center_mm,
    input  logic [11:0]                   depth_mm,
    output logic                          out_valid,
    output okb_pkg::side_t                out_side,
    output logic signed [okb_pkg::CW-1:0] out_x [0:3],
    output logic signed [okb_pkg::CW-1:0] out_y [0:3]
);
    import okb_pkg::*;

    localparam int PW = AW + RW;   // product
    localparam int SW = PW + 1;    // sum of two products
    localparam logic signed [SW-1:0] ROUND = SW'(64'sd1073741824);
    localparam logic signed [CW:0]   CMAX  = (CW+1)'(8388607);
    localparam logic signed [CW:0]   CMIN  = -(CW+1)'(8388608);

    // Round a Q30 offset in half millimetres, add to pose, saturate
    function automatic logic signed [CW-1:0] place(input logic signed [CW-1:0] pose,
                                                   input logic signed [SW-1:0] off);
        logic signed [SW-1:0] r;
        logic signed [CW:0]   v;
        r = (off + ROUND) >>> 31;
        // rounded offset is a few thousand mm, so its low CW+1 bits carry the sign
        v = {pose[CW-1], pose} + r[CW:0];
        if (v > CMAX) begin
            return CMAX[CW-1:0];
        end else if (v < CMIN) begin
            return CMIN[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    logic signed [AW-1:0] a_front, a_rear, b_w;

    // Along offsets: front face and near face; across: half width times two
    assign a_rear  = AW'(center_mm) + AW'(center_mm) + AW'({1'b0, length_mm});
    assign a_front = a_rear + AW'({1'b0, depth_mm}) + AW'({1'b0, depth_mm});
    assign b_w     = AW'({1'b0, width_mm});

    // Stage 1: products
    logic                 m_valid_reg;
    side_t                m_side_reg;
    logic signed [PW-1:0] fc_reg, fs_reg, rc_reg, rs_reg, wc_reg, ws_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_side_reg <= in_side;
            fc_reg     <= a_front * in_cos;
            fs_reg     <= a_front * in_sin;
            rc_reg     <= a_rear * in_cos;
            rs_reg     <= a_rear * in_sin;
            wc_reg     <= b_w * in_cos;
            ws_reg     <= b_w * in_sin;
        end
    end

    // Stage 2: rotated offsets of the four corners
    logic                 s_valid_reg;
    side_t                s_side_reg;
    logic signed [SW-1:0] ox_reg [0:3];
    logic signed [SW-1:0] oy_reg [0:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_valid_reg <= 1'b0;
        end else if (en) begin
            s_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_side_reg <= m_side_reg;
            ox_reg[0]  <= SW'(fc_reg) - SW'(ws_reg);
            oy_reg[0]  <= SW'(fs_reg) + SW'(wc_reg);
            ox_reg[1]  <= SW'(fc_reg) + SW'(ws_reg);
            oy_reg[1]  <= SW'(fs_reg) - SW'(wc_reg);
            ox_reg[2]  <= SW'(rc_reg) + SW'(ws_reg);
            oy_reg[2]  <= SW'(rs_reg) - SW'(wc_reg);
            ox_reg[3]  <= SW'(rc_reg) - SW'(ws_reg);
            oy_reg[3]  <= SW'(rs_reg) + SW'(wc_reg);
        end
    end

    // Stage 3: place on the map
    logic                 p_valid_reg;
    side_t                p_side_reg;
    logic signed [CW-1:0] px_reg [0:3];
    logic signed [CW-1:0] py_reg [0:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_side_reg <= s_side_reg;
            for (int k = 0; k < 4; k++) begin
                px_reg[k] <= place(s_side_reg.pose_x, ox_reg[k]);
                py_reg[k] <= place(s_side_reg.pose_y, oy_reg[k]);
            end
        end
    end

    assign out_valid = p_valid_reg;
    assign out_side  = p_side_reg;
    assign out_x     = px_reg;
    assign out_y     = py_reg;

endmodule
